// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the design files; the vector unit core includes them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checks a property on every rising clock edge outside of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// Checks that an expression is never true outside of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	`ASSERT_PROP(lbl, clk, rst_n, !(expr))
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== design/vau_pkg.sv =====
// ---------------------------------------------------------------------------
// vau_pkg
// Types, constants and helper functions of the 3D vector arithmetic unit.
// ---------------------------------------------------------------------------
`default_nettype none
package vau_pkg;

	// Command codes; code 7 is unused and yields an all-zero result.
	typedef enum logic [2:0] {
		CMD_ADD   = 3'd0,
		CMD_SUB   = 3'd1,
		CMD_SCALE = 3'd2,
		CMD_DOT   = 3'd3,
		CMD_CROSS = 3'd4,
		CMD_LEN   = 3'd5,
		CMD_NORM  = 3'd6
	} cmd_e;

	// Square root: one result bit per stage plus a rounding stage.
	localparam int SQRT_ITER = 32;
	localparam int SQRT_LAT  = SQRT_ITER + 1;
	// Normalize divider: one quotient bit per stage.
	localparam int DIV_STEPS = 17;
	// Input register, product, difference and lane rounding stages.
	localparam int FRONT_LAT = 4;
	localparam int PIPE_LAT  = FRONT_LAT + SQRT_LAT + DIV_STEPS;
	// Edges from an accepted beat to the edge that samples its result.
	localparam int RESULT_LAT = PIPE_LAT + 1;

	// One saturated Q16.16 value and its overflow mark.
	typedef struct packed {
		logic signed [31:0] val;
		logic               ov;
	} lane_res_t;

	// Result of everything but the root-based commands.
	typedef struct packed {
		cmd_e               cmd;
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
		logic signed [31:0] sc;
		logic               ov;
	} early_t;

	// Result once the root is known; the divider supplies the rest.
	typedef struct packed {
		early_t     e;
		logic       zl;
		logic [2:0] neg;
	} late_t;

	// Round a Q32.32 value half up to Q16.16.
	function automatic logic signed [66:0] round_q(input logic signed [66:0] v);
		logic signed [66:0] t;
		t = v + 67'sh8000;
		return t >>> 16;
	endfunction

	// Saturate to the signed 32-bit range.
	function automatic lane_res_t sat32(input logic signed [66:0] v);
		lane_res_t r;
		r.ov = 1'b0;
		r.val = v[31:0];
		if (v > 67'sh7FFFFFFF) begin
			r.val = 32'sh7FFFFFFF;
			r.ov = 1'b1;
		end else if (v < ~67'sh7FFFFFFF) begin
			r.val = 32'sh80000000;
			r.ov = 1'b1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/vector3_arithmetic_unit_core.sv =====
// ---------------------------------------------------------------------------
// vector3_arithmetic_unit_core
// Q16.16 3D vector unit: add, subtract, scale, dot, cross, length, normalize.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// command   in         start high, busy low    command, ax..bz, scale_factor
// result    out        done strobe, one cycle  rx, ry, rz, scalar_out, flags
//
// A beat is taken in every cycle; busy stays low.
// Each result passes through four front stages,
// 33 square root stages and 17 divider stages, then the output register.
// Every command goes through the same pipeline, so results keep their order.
// Reset clears the valid line and the strobe; the receiver cannot stall.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module vector3_arithmetic_unit_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         command,
	input  logic signed [31:0] ax,
	input  logic signed [31:0] ay,
	input  logic signed [31:0] az,
	input  logic signed [31:0] bx,
	input  logic signed [31:0] by,
	input  logic signed [31:0] bz,
	input  logic signed [31:0] scale_factor,
	output logic               done,
	output logic signed [31:0] rx,
	output logic signed [31:0] ry,
	output logic signed [31:0] rz,
	output logic signed [31:0] scalar_out,
	output logic               overflow,
	output logic               zero_length
);
	import vau_pkg::*;

	logic               valid_q [PIPE_LAT];
	cmd_e               cmd_s1;
	logic signed [31:0] a_s1 [3];
	logic signed [31:0] b_s1 [3];
	logic signed [31:0] s_s1;
	cmd_e               cmd_line [3];
	logic signed [63:0] prod_s3 [3];
	lane_res_t          lane_s4 [3];
	logic signed [65:0] dot_s4;
	logic [63:0]        sq_s4;
	lane_res_t          dot_res;
	early_t             early_d;
	early_t             early_line [SQRT_LAT];
	logic signed [31:0] a_line [SQRT_LAT+3][3];
	logic [32:0]        root;
	late_t              late_d;
	late_t              late_line [DIV_STEPS];
	logic [48:0]        numer [3];
	logic [16:0]        quot [3];
	late_t              fin;
	logic signed [31:0] nrm [3];

	assign busy = 1'b0;

	// Valid line through every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_LAT; i++) valid_q[i] <= 1'b0;
		end else begin
			valid_q[0] <= start && !busy;
			for (int i = 1; i < PIPE_LAT; i++) valid_q[i] <= valid_q[i-1];
		end
	end

	// Stage 1: input register.
	always_ff @(posedge clk) begin
		cmd_s1  <= cmd_e'(command);
		a_s1[0] <= ax;
		a_s1[1] <= ay;
		a_s1[2] <= az;
		b_s1[0] <= bx;
		b_s1[1] <= by;
		b_s1[2] <= bz;
		s_s1    <= scale_factor;
	end

	// Component lanes.
	for (genvar i = 0; i < 3; i++) begin : g_lane
		vau_lane u_lane (
			.clk     (clk),
			.cmd     (cmd_s1),
			.a       (a_s1[i]),
			.b       (b_s1[i]),
			.s       (s_s1),
			.a_n1    (a_s1[(i+1)%3]),
			.b_n1    (b_s1[(i+1)%3]),
			.a_n2    (a_s1[(i+2)%3]),
			.b_n2    (b_s1[(i+2)%3]),
			.prod_s3 (prod_s3[i]),
			.res_s4  (lane_s4[i])
		);
	end

	// Command delay alongside the lanes.
	always_ff @(posedge clk) begin
		cmd_line[0] <= cmd_s1;
		cmd_line[1] <= cmd_line[0];
		cmd_line[2] <= cmd_line[1];
	end

	// Stage 4: merge of the lane products into dot sum and sum of squares.
	always_ff @(posedge clk) begin
		dot_s4 <= 66'(prod_s3[0]) + 66'(prod_s3[1]) + 66'(prod_s3[2]);
		sq_s4  <= 64'(prod_s3[0]) + 64'(prod_s3[1]) + 64'(prod_s3[2]);
	end

	assign dot_res = sat32(round_q(67'(dot_s4)));

	// Stage 5: result for all commands that need no root.
	always_comb begin
		early_d.cmd = cmd_line[2];
		early_d.rx  = lane_s4[0].val;
		early_d.ry  = lane_s4[1].val;
		early_d.rz  = lane_s4[2].val;
		early_d.sc  = '0;
		early_d.ov  = lane_s4[0].ov | lane_s4[1].ov | lane_s4[2].ov;
		if (cmd_line[2] == CMD_DOT) begin
			early_d.sc = dot_res.val;
			early_d.ov = dot_res.ov;
		end
	end

	// Delay lines that wait for the root.
	always_ff @(posedge clk) begin
		early_line[0] <= early_d;
		for (int k = 1; k < SQRT_LAT; k++) early_line[k] <= early_line[k-1];
		a_line[0] <= a_s1;
		for (int k = 1; k < SQRT_LAT + 3; k++) a_line[k] <= a_line[k-1];
	end

	vau_isqrt u_isqrt (
		.clk  (clk),
		.sq   (sq_s4),
		.root (root)
	);

	// Root arrives: length result, zero check and divider operands.
	always_comb begin
		late_d.e  = early_line[SQRT_LAT-1];
		late_d.zl = (late_d.e.cmd == CMD_NORM) && (root == '0);
		for (int i = 0; i < 3; i++) late_d.neg[i] = a_line[SQRT_LAT+2][i][31];
		if (late_d.e.cmd == CMD_LEN) begin
			if (root[32] || root[31]) begin
				late_d.e.sc = 32'sh7FFFFFFF;
				late_d.e.ov = 1'b1;
			end else begin
				late_d.e.sc = $signed(root[31:0]);
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_div
		logic [31:0] mag;
		assign mag = a_line[SQRT_LAT+2][i][31] ? 32'(-a_line[SQRT_LAT+2][i])
			: 32'(a_line[SQRT_LAT+2][i]);
		assign numer[i] = {mag, 17'b0} + 49'(root);

		vau_div u_div (
			.clk   (clk),
			.numer (numer[i]),
			.den   ({root, 1'b0}),
			.quot  (quot[i])
		);
	end

	always_ff @(posedge clk) begin
		late_line[0] <= late_d;
		for (int k = 1; k < DIV_STEPS; k++) late_line[k] <= late_line[k-1];
	end

	// Final select and output register.
	assign fin = late_line[DIV_STEPS-1];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nrm[i] = fin.neg[i] ? -32'(quot[i]) : 32'(quot[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_q[PIPE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		scalar_out  <= fin.e.sc;
		zero_length <= fin.zl;
		if (fin.e.cmd == CMD_NORM) begin
			overflow <= 1'b0;
			if (fin.zl) begin
				rx <= '0;
				ry <= '0;
				rz <= '0;
			end else begin
				rx <= nrm[0];
				ry <= nrm[1];
				rz <= nrm[2];
			end
		end else begin
			rx       <= fin.e.rx;
			ry       <= fin.e.ry;
			rz       <= fin.e.rz;
			overflow <= fin.e.ov;
		end
	end

	// Every accepted beat yields exactly one result after the fixed latency.
	`ASSERT_PROP(a_beat_result, clk, arst_n, start |-> ##RESULT_LAT done)
	`ASSERT_PROP(a_no_spurious, clk, arst_n, !start |-> ##RESULT_LAT !done)
	// A zero-length result carries a zero vector and no overflow.
	`ASSERT_NEVER(a_zero_len_shape, clk, arst_n,
		done && zero_length && (overflow || rx != 0 || ry != 0 || rz != 0))

endmodule
`default_nettype wire

// ===== design/vau_lane.sv =====
// ---------------------------------------------------------------------------
// vau_lane
// One component lane: add/subtract, products, cross difference and rounding.
// ---------------------------------------------------------------------------
`default_nettype none
module vau_lane (
	input  logic                clk,
	input  vau_pkg::cmd_e       cmd,
	input  logic signed [31:0]  a,
	input  logic signed [31:0]  b,
	input  logic signed [31:0]  s,
	input  logic signed [31:0]  a_n1,
	input  logic signed [31:0]  b_n1,
	input  logic signed [31:0]  a_n2,
	input  logic signed [31:0]  b_n2,
	output logic signed [63:0]  prod_s3,
	output vau_pkg::lane_res_t  res_s4
);
	import vau_pkg::*;

	logic signed [31:0] m1a, m1b;
	logic signed [63:0] p1_s2, p2_s2;
	logic signed [32:0] as_s2;
	cmd_e               cmd_s2, cmd_s3;
	logic signed [64:0] diff_s3;
	lane_res_t          as_s3;
	lane_res_t          rnd;

	// The first multiplier serves scale, dot, squares and the cross term.
	always_comb begin
		case (cmd)
			CMD_SCALE: begin m1a = a; m1b = s; end
			CMD_LEN, CMD_NORM: begin m1a = a; m1b = a; end
			CMD_CROSS: begin m1a = a_n1; m1b = b_n2; end
			default: begin m1a = a; m1b = b; end
		endcase
	end

	// Stage 2: products and the raw sum or difference.
	always_ff @(posedge clk) begin
		p1_s2  <= 64'(m1a) * 64'(m1b);
		p2_s2  <= 64'(a_n2) * 64'(b_n1);
		as_s2  <= (cmd == CMD_SUB) ? 33'(a) - 33'(b) : 33'(a) + 33'(b);
		cmd_s2 <= cmd;
	end

	// Stage 3: exact cross difference and saturated add/subtract.
	always_ff @(posedge clk) begin
		diff_s3 <= (cmd_s2 == CMD_CROSS) ? 65'(p1_s2) - 65'(p2_s2) : 65'(p1_s2);
		prod_s3 <= p1_s2;
		as_s3   <= sat32(67'(as_s2));
		cmd_s3  <= cmd_s2;
	end

	assign rnd = sat32(round_q(67'(diff_s3)));

	// Stage 4: lane result for the vector commands.
	always_ff @(posedge clk) begin
		case (cmd_s3)
			CMD_ADD, CMD_SUB: res_s4 <= as_s3;
			CMD_SCALE, CMD_CROSS: res_s4 <= rnd;
			default: res_s4 <= '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== design/vau_isqrt.sv =====
// ---------------------------------------------------------------------------
// vau_isqrt
// Pipelined integer square root of a 64-bit value, rounded to nearest.
// ---------------------------------------------------------------------------
`default_nettype none
module vau_isqrt (
	input  logic        clk,
	input  logic [63:0] sq,
	output logic [32:0] root
);
	import vau_pkg::*;

	logic [63:0] rem_q [SQRT_ITER];
	logic [63:0] res_q [SQRT_ITER];

	// One result bit per stage, from the top pair of bits down.
	for (genvar j = 0; j < SQRT_ITER; j++) begin : g_step
		localparam logic [63:0] BITV = 64'(1) << (62 - 2 * j);
		logic [63:0] rem_in, res_in;
		logic [64:0] trial;
		logic        take;

		if (j == 0) begin : g_first
			assign rem_in = sq;
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[j-1];
			assign res_in = res_q[j-1];
		end

		assign trial = {1'b0, res_in} + {1'b0, BITV};
		assign take  = {1'b0, rem_in} >= trial;

		always_ff @(posedge clk) begin
			rem_q[j] <= take ? rem_in - trial[63:0] : rem_in;
			res_q[j] <= take ? (res_in >> 1) + BITV : (res_in >> 1);
		end
	end

	// Round to nearest: ties cannot occur for an integer radicand.
	always_ff @(posedge clk) begin
		if (rem_q[SQRT_ITER-1] > res_q[SQRT_ITER-1]) begin
			root <= res_q[SQRT_ITER-1][32:0] + 33'd1;
		end else begin
			root <= res_q[SQRT_ITER-1][32:0];
		end
	end

endmodule
`default_nettype wire

// ===== design/vau_div.sv =====
// ---------------------------------------------------------------------------
// vau_div
// Pipelined restoring divider for one normalized component.
// ---------------------------------------------------------------------------
`default_nettype none
module vau_div (
	input  logic        clk,
	input  logic [48:0] numer,
	input  logic [33:0] den,
	output logic [16:0] quot
);
	import vau_pkg::*;

	logic [48:0] rem_q [DIV_STEPS];
	logic [16:0] quo_q [DIV_STEPS];
	logic [33:0] den_q [DIV_STEPS];

	// The quotient never exceeds one in Q16.16, so 17 bits are enough.
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		localparam int K = DIV_STEPS - 1 - j;
		logic [48:0] rem_in;
		logic [16:0] quo_in;
		logic [33:0] den_in;
		logic [50:0] trial;
		logic        take;

		if (j == 0) begin : g_first
			assign rem_in = numer;
			assign quo_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_q[j-1];
			assign quo_in = quo_q[j-1];
			assign den_in = den_q[j-1];
		end

		assign trial = 51'(den_in) << K;
		assign take  = 51'(rem_in) >= trial;

		always_ff @(posedge clk) begin
			rem_q[j] <= take ? 49'(51'(rem_in) - trial) : rem_in;
			quo_q[j] <= {quo_in[15:0], take};
			den_q[j] <= den_in;
		end
	end

	assign quot = quo_q[DIV_STEPS-1];

endmodule
`default_nettype wire

// ===== verif/vector3_arithmetic_unit_core_test.sv =====
// ---------------------------------------------------------------------------
// vector3_arithmetic_unit_core_test
// Self-checking bench for the Q16.16 vector unit. A table of directed beats
// covers the extremes, every command, the unused code and the zero vector
// normalize. About a thousand random beats follow. Every result is compared
// field by field with a hand-written result or the bench's bit-exact model.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vector3_arithmetic_unit_core_test;
	import vau_pkg::*;

	localparam logic [2:0] CMD_SPARE = 3'd7;
	localparam int N_RANDOM   = 1000;
	localparam int STALL_MAX  = 1000;
	localparam logic signed [31:0] QMAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] QMIN = 32'sh80000000;
	localparam logic signed [31:0] QONE = 32'sh00010000;

	typedef struct {
		logic [2:0]         cmd;
		logic signed [31:0] a [3];
		logic signed [31:0] b [3];
		logic signed [31:0] s;
	} vec_beat_t;

	typedef struct {
		logic signed [31:0] r [3];
		logic signed [31:0] sc;
		logic               ov;
		logic               zl;
	} vec_res_t;

	typedef struct {
		vec_beat_t t;
		bit        known;
		vec_res_t  res;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] command = '0;
	logic signed [31:0] ax = '0, ay = '0, az = '0;
	logic signed [31:0] bx = '0, by = '0, bz = '0;
	logic signed [31:0] scale_factor = '0;
	logic busy, done, overflow, zero_length;
	logic signed [31:0] rx, ry, rz, scalar_out;

	vec_res_t   pending_q [$];
	table_row_t dir_q [$];
	int errors = 0;
	int stall_cnt = 0;

	vector3_arithmetic_unit_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .ax(ax), .ay(ay), .az(az),
		.bx(bx), .by(by), .bz(bz), .scale_factor(scale_factor),
		.done(done), .rx(rx), .ry(ry), .rz(rz), .scalar_out(scalar_out),
		.overflow(overflow), .zero_length(zero_length)
	);

	// Clock generation.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Round a Q32.32 value half up to Q16.16.
	function automatic logic signed [66:0] round_half_up(logic signed [66:0] v);
		return (v + 67'sd32768) >>> 16;
	endfunction

	// Clamp to the signed 32-bit range and note saturation.
	function automatic logic signed [31:0] clamp32(logic signed [66:0] v, inout logic ov);
		if (v > 67'sh7FFFFFFF) begin
			ov = 1'b1;
			return QMAX;
		end
		if (v < -67'sh80000000) begin
			ov = 1'b1;
			return QMIN;
		end
		return v[31:0];
	endfunction

	// Square root rounded to nearest.
	function automatic logic [63:0] root_nearest(logic [63:0] s);
		logic [63:0] res, bits, rem;
		res = '0;
		bits = 64'd1 << 62;
		rem = s;
		while (bits > rem) bits = bits >> 2;
		while (bits != 0) begin
			if (rem >= res + bits) begin
				rem = rem - (res + bits);
				res = (res >> 1) + bits;
			end else begin
				res = res >> 1;
			end
			bits = bits >> 2;
		end
		if (rem > res) res = res + 1;
		return res;
	endfunction

	// Expected result of one beat.
	function automatic vec_res_t vector_result(vec_beat_t t);
		vec_res_t o;
		logic signed [66:0] a [3];
		logic signed [66:0] b [3];
		logic signed [66:0] s, acc;
		logic [66:0] sq;
		logic [63:0] root, mag, q;
		o.r = '{0, 0, 0};
		o.sc = '0;
		o.ov = 1'b0;
		o.zl = 1'b0;
		for (int i = 0; i < 3; i++) begin
			a[i] = 67'(t.a[i]);
			b[i] = 67'(t.b[i]);
		end
		s = 67'(t.s);
		case (t.cmd)
			CMD_ADD: for (int i = 0; i < 3; i++) o.r[i] = clamp32(a[i] + b[i], o.ov);
			CMD_SUB: for (int i = 0; i < 3; i++) o.r[i] = clamp32(a[i] - b[i], o.ov);
			CMD_SCALE: for (int i = 0; i < 3; i++)
				o.r[i] = clamp32(round_half_up(a[i] * s), o.ov);
			CMD_DOT: begin
				acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
				o.sc = clamp32(round_half_up(acc), o.ov);
			end
			CMD_CROSS: begin
				o.r[0] = clamp32(round_half_up(a[1] * b[2] - a[2] * b[1]), o.ov);
				o.r[1] = clamp32(round_half_up(a[2] * b[0] - a[0] * b[2]), o.ov);
				o.r[2] = clamp32(round_half_up(a[0] * b[1] - a[1] * b[0]), o.ov);
			end
			CMD_LEN, CMD_NORM: begin
				sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
				root = root_nearest(sq[63:0]);
				if (t.cmd == CMD_LEN) begin
					if (root > 64'h7FFFFFFF) begin
						o.sc = QMAX;
						o.ov = 1'b1;
					end else begin
						o.sc = root[31:0];
					end
				end else if (root == 0) begin
					o.zl = 1'b1;
				end else begin
					for (int i = 0; i < 3; i++) begin
						mag = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
						mag = mag << 16;
						q = (mag * 2 + root) / (2 * root);
						o.r[i] = (a[i] < 0) ? -q[31:0] : q[31:0];
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// One line per mismatch, counted.
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
	endtask

	// Result beats are checked against the oldest expectation.
	always @(posedge clk) begin
		vec_res_t e;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t result beat with nothing expected", $realtime);
			end else begin
				e = pending_q.pop_front();
				if (rx !== e.r[0]) report_mismatch("rx", rx, e.r[0]);
				if (ry !== e.r[1]) report_mismatch("ry", ry, e.r[1]);
				if (rz !== e.r[2]) report_mismatch("rz", rz, e.r[2]);
				if (scalar_out !== e.sc) report_mismatch("scalar_out", scalar_out, e.sc);
				if (overflow !== e.ov) report_mismatch("overflow", overflow, e.ov);
				if (zero_length !== e.zl) report_mismatch("zero_length", zero_length, e.zl);
			end
		end
	end

	// Watchdog on cycles in which no beat moves on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) stall_cnt <= 0;
			else stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_MAX) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Drive one command beat and hold it until taken.
	task automatic send_beat(vec_beat_t t, bit known, vec_res_t res);
		command <= t.cmd;
		ax <= t.a[0];
		ay <= t.a[1];
		az <= t.a[2];
		bx <= t.b[0];
		by <= t.b[1];
		bz <= t.b[2];
		scale_factor <= t.s;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_q.push_back(known ? res : vector_result(t));
	endtask

	task automatic add_row(logic [2:0] c, logic signed [31:0] a0, a1, a2,
			logic signed [31:0] b0, b1, b2, s);
		table_row_t row;
		row.t.cmd = c;
		row.t.a = '{a0, a1, a2};
		row.t.b = '{b0, b1, b2};
		row.t.s = s;
		row.known = 1'b0;
		dir_q.push_back(row);
	endtask

	// Attach a hand-written result to the last table row.
	task automatic set_known(logic signed [31:0] r0, r1, r2, sc, logic ov, zl);
		dir_q[$].known = 1'b1;
		dir_q[$].res.r = '{r0, r1, r2};
		dir_q[$].res.sc = sc;
		dir_q[$].res.ov = ov;
		dir_q[$].res.zl = zl;
	endtask

	// Random Q16.16 value: full range, small, or an extreme.
	function automatic logic signed [31:0] pick_value();
		logic signed [31:0] v;
		case ($urandom_range(0, 9))
			0: v = QMAX;
			1: v = QMIN;
			2: v = 32'($signed($urandom_range(0, 6)) - 3) <<< 16;
			3, 4, 5: v = $urandom;
			default: v = $signed({{13{$urandom_range(0, 1) == 1}}, 19'($urandom)});
		endcase
		return v;
	endfunction

	// Stimulus.
	initial begin
		vec_beat_t t;
		vec_res_t none;
		none = '{r: '{0, 0, 0}, sc: 0, ov: 0, zl: 0};

		add_row(CMD_ADD, QMAX, 1, 0, 1, 1, 0, 0);
		set_known(QMAX, 2, 0, 0, 1'b1, 1'b0);
		add_row(CMD_SUB, QMIN, 0, 0, 1, 0, 0, 0);
		set_known(QMIN, 0, 0, 0, 1'b1, 1'b0);
		add_row(CMD_NORM, 0, 0, 0, QMAX, QMIN, 5, QONE);
		set_known(0, 0, 0, 0, 1'b0, 1'b1);
		add_row(CMD_SPARE, QMAX, QMAX, QMAX, QMIN, QMIN, QMIN, QMAX);
		set_known(0, 0, 0, 0, 1'b0, 1'b0);
		add_row(CMD_LEN, 0, 0, 0, QMAX, 0, 0, 0);
		set_known(0, 0, 0, 0, 1'b0, 1'b0);
		add_row(CMD_ADD, 0, 0, 0, 0, 0, 0, 0);
		set_known(0, 0, 0, 0, 1'b0, 1'b0);
		add_row(CMD_SUB, QMAX, QMIN, 0, QMIN, QMAX, 0, 0);
		add_row(CMD_SCALE, QMAX, QMIN, 32'sh18000, 0, 0, 0, QONE);
		add_row(CMD_SCALE, QMIN, QMAX, -1, 0, 0, 0, QMIN);
		add_row(CMD_SCALE, 32'sh8000, -32'sh8000, 3, 0, 0, 0, 32'sh8000);
		add_row(CMD_DOT, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, 0);
		add_row(CMD_DOT, QONE, 32'sh20000, -QONE, 32'sh30000, QONE, 32'sh8000, 0);
		add_row(CMD_CROSS, QONE, 0, 0, 0, QONE, 0, 0);
		add_row(CMD_CROSS, QMAX, QMIN, QMAX, QMIN, QMAX, QMIN, 0);
		add_row(CMD_CROSS, 32'sh12345, -32'sh6789, 32'sh40000, 7, -32'sh10000, 32'sh3, 0);
		add_row(CMD_LEN, QMIN, QMIN, QMIN, 0, 0, 0, 0);
		add_row(CMD_LEN, 32'sh30000, 32'sh40000, 0, 0, 0, 0, 0);
		add_row(CMD_NORM, QMIN, 0, 0, 0, 0, 0, 0);
		add_row(CMD_NORM, 1, 0, 0, 0, 0, 0, 0);
		add_row(CMD_NORM, QMAX, -32'sh5, 32'sh1234567, 0, 0, 0, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (dir_q[i]) send_beat(dir_q[i].t, dir_q[i].known, dir_q[i].res);

		// Random beats; a stretch in the middle is sent with no idling.
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 600) begin
				start <= 1'b0;
				@(posedge clk);
				while (pending_q.size() != 0) @(posedge clk);
			end else if (n < 250 || n >= 450) begin
				while ($urandom_range(0, 99) < 34) begin
					start <= 1'b0;
					@(posedge clk);
				end
			end
			t.cmd = 3'($urandom_range(0, 7));
			for (int i = 0; i < 3; i++) begin
				t.a[i] = pick_value();
				t.b[i] = pick_value();
			end
			if (t.cmd == CMD_NORM && $urandom_range(0, 9) == 0) t.a = '{0, 0, 0};
			t.s = pick_value();
			send_beat(t, 1'b0, none);
		end
		start <= 1'b0;

		// Drain.
		while (pending_q.size() != 0) @(posedge clk);
		repeat (RESULT_LAT + 10) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
